>>> hw/rtl/lsmt_pkg.sv
`default_nettype none
package lsmt_pkg;

	// Fixed field widths
	localparam int SLOPE_W    = 32;
	localparam int ANG_W      = 16;
	localparam int EI_W       = 6;
	localparam int CNT_W      = 7;
	localparam int OUT_X_W    = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int ALIM_W     = 16;
	localparam int DLIM_W     = 12;
	localparam int RHS_W      = 88;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_LINES  = 64;
	localparam int DEF_COORD_BITS = 12;

	// Angle unit and near-test pipeline
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_W       = 22;
	localparam int NEAR_LAT     = 5;

	localparam logic signed [SLOPE_W-1:0] S_MAX = 32'sh7FFFFFFF;
	localparam logic signed [SLOPE_W-1:0] S_MIN = 32'sh80000000;

	localparam logic [ALIM_W-1:0] ANGLE_LIMIT_RST = 16'd768;
	localparam logic [DLIM_W-1:0] DIST_LIMIT_RST  = 12'd5;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_LIMIT = 1'b0,
		REG_DIST_LIMIT  = 1'b1
	} cfg_reg_t;

	// atan(2^-i) in 1/65536 degree, scale 180/3.14
	function automatic logic [ATAN_W-1:0] atan_lut(input logic [3:0] i);
		logic [ATAN_W-1:0] v;
		unique case (i)
			4'd0:  v = 22'd2950616;
			4'd1:  v = 22'd1741850;
			4'd2:  v = 22'd920346;
			4'd3:  v = 22'd467182;
			4'd4:  v = 22'd234498;
			4'd5:  v = 22'd117363;
			4'd6:  v = 22'd58696;
			4'd7:  v = 22'd29350;
			4'd8:  v = 22'd14675;
			4'd9:  v = 22'd7338;
			4'd10: v = 22'd3669;
			4'd11: v = 22'd1834;
			4'd12: v = 22'd917;
			4'd13: v = 22'd459;
			4'd14: v = 22'd229;
			4'd15: v = 22'd115;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lsmt_cell.sv
`default_nettype none
module lsmt_cell #(
	parameter int EW = 104
) (
	input  wire logic          clk,
	input  wire logic          shift_en,
	input  wire logic [EW-1:0] d_in,
	output logic      [EW-1:0] q
);

	logic [EW-1:0] entry_q;

	// take the neighbour's entry on each ring step
	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= d_in;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

>>> hw/rtl/lsmt_div.sv
`default_nettype none
module lsmt_div #(
	parameter int CB = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [CB-1:0]    num,
	input  wire logic [CB-1:0]    den,
	output logic                  done,
	output logic      [CB+15:0]   quot
);

	localparam int NQ = CB + 16;
	localparam int CW = $clog2(NQ + 1);

	logic [NQ-1:0] qr_q;
	logic [CB-1:0] rem_q;
	logic [CB-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [CB:0]   trial;
	logic          ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, qr_q[NQ-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NQ - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qr_q  <= {num, 16'b0};
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? CB'(trial - {1'b0, den_q}) : trial[CB-1:0];
			qr_q  <= {qr_q[NQ-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = qr_q;

endmodule
`default_nettype wire

>>> hw/rtl/lsmt_cordic.sv
`default_nettype none
module lsmt_cordic #(
	parameter int CB = 12
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [CB:0]                 dx,
	input  wire logic signed [CB:0]                 dy,
	output logic signed [lsmt_pkg::ANG_W-1:0]       angle
);

	localparam int VW = CB + 14;
	localparam int ZW = 26;

	logic signed [VW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [4:0]           step_q;
	logic                 flat_q;
	logic signed [VW-1:0] dx_e, dy_e, sx, sy;
	logic signed [ZW-1:0] tab, zr;
	logic                 run;

	// arithmetic shift that rounds toward zero
	function automatic logic signed [VW-1:0] shr_tz(input logic signed [VW-1:0] v,
			input logic [3:0] s);
		logic signed [VW-1:0] r;
		if (v[VW-1]) begin
			r = -((-v) >>> s);
		end else begin
			r = v >>> s;
		end
		return r;
	endfunction

	assign run = step_q < 5'(lsmt_pkg::CORDIC_STEPS);

	// fold into the right half plane
	always_comb begin
		dx_e = VW'(dx);
		dy_e = VW'(dy);
		if (dx[CB]) begin
			dx_e = -dx_e;
			dy_e = -dy_e;
		end
	end

	assign sx  = shr_tz(x_q, step_q[3:0]);
	assign sy  = shr_tz(y_q, step_q[3:0]);
	assign tab = $signed({{(ZW-lsmt_pkg::ATAN_W){1'b0}}, lsmt_pkg::atan_lut(step_q[3:0])});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 5'(lsmt_pkg::CORDIC_STEPS);
		end else if (start) begin
			step_q <= '0;
		end else if (run) begin
			step_q <= step_q + 1'b1;
		end
	end

	// rotate toward the x axis, one step per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= dx_e <<< 10;
			y_q    <= dy_e <<< 10;
			z_q    <= '0;
			flat_q <= (dy == '0);
		end else if (run) begin
			if (y_q > 0) begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - tab;
			end
		end
	end

	// round half away from zero to Q8.8
	always_comb begin
		if (z_q[ZW-1]) begin
			zr = -((-z_q + ZW'(128)) >>> 8);
		end else begin
			zr = (z_q + ZW'(128)) >>> 8;
		end
	end

	assign angle = flat_q ? '0 : lsmt_pkg::ANG_W'(zr);

endmodule
`default_nettype wire

>>> hw/rtl/lsmt_near.sv
`default_nettype none
module lsmt_near #(
	parameter int CB = 12
) (
	input  wire logic                                   clk,
	input  wire logic signed [lsmt_pkg::SLOPE_W-1:0]    seg_slope,
	input  wire logic signed [lsmt_pkg::SLOPE_W-1:0]    seg_icpt,
	input  wire logic signed [lsmt_pkg::ANG_W-1:0]      seg_angle,
	input  wire logic        [CB-1:0]                   seg_xl,
	input  wire logic        [CB-1:0]                   seg_xh,
	input  wire logic signed [lsmt_pkg::SLOPE_W-1:0]    ln_slope,
	input  wire logic signed [lsmt_pkg::SLOPE_W-1:0]    ln_icpt,
	input  wire logic signed [lsmt_pkg::ANG_W-1:0]      ln_angle,
	input  wire logic        [CB-1:0]                   ln_xl,
	input  wire logic        [CB-1:0]                   ln_xh,
	input  wire logic        [lsmt_pkg::ALIM_W-1:0]     angle_limit,
	input  wire logic        [lsmt_pkg::RHS_W-1:0]      rhs,
	output logic                                        near
);

	localparam int AW   = lsmt_pkg::ANG_W + 1;
	localparam int DW   = CB + 35;
	localparam int H    = (DW + 1) / 2;
	localparam int LW   = 2 * DW;
	localparam int CMPW = (LW > lsmt_pkg::RHS_W) ? LW : lsmt_pkg::RHS_W;

	logic signed [AW-1:0] ad;
	logic [AW-1:0]        adm;
	logic [CB-1:0]        xsel;

	logic                 ang_s1, ang_s2, ang_s3, ang_s4, near_s5;
	logic [CB-1:0]        x_s1;
	logic signed [32:0]   ds_s1, db_s1;
	logic signed [DW-1:0] d_s2;
	logic [DW-1:0]        dm_s3;
	logic [2*(DW-H)-1:0]  phh_s4;
	logic [DW-1:0]        phl_s4;
	logic [2*H-1:0]       pll_s4;
	logic [LW-1:0]        lhs;

	// angle bound and nearest x
	assign ad  = {seg_angle[lsmt_pkg::ANG_W-1], seg_angle} - {ln_angle[lsmt_pkg::ANG_W-1], ln_angle};
	assign adm = ad[AW-1] ? AW'(-ad) : AW'(ad);

	always_comb begin
		priority if (seg_xh < ln_xl) begin
			xsel = seg_xh;
		end else if (seg_xl > ln_xh) begin
			xsel = ln_xh;
		end else if (seg_xh < ln_xh) begin
			xsel = seg_xh;
		end else begin
			xsel = seg_xl;
		end
	end

	assign lhs = (LW'(phh_s4) << (2 * H)) + (LW'(phl_s4) << (H + 1)) + LW'(pll_s4);

	// offset squared against the scaled bound, five stages
	always_ff @(posedge clk) begin
		ang_s1  <= adm < {1'b0, angle_limit};
		x_s1    <= xsel;
		ds_s1   <= {seg_slope[31], seg_slope} - {ln_slope[31], ln_slope};
		db_s1   <= {seg_icpt[31], seg_icpt} - {ln_icpt[31], ln_icpt};

		ang_s2  <= ang_s1;
		d_s2    <= $signed({1'b0, x_s1}) * ds_s1 + db_s1;

		ang_s3  <= ang_s2;
		dm_s3   <= d_s2[DW-1] ? DW'(-d_s2) : DW'(d_s2);

		ang_s4  <= ang_s3;
		phh_s4  <= dm_s3[DW-1:H] * dm_s3[DW-1:H];
		phl_s4  <= DW'(dm_s3[DW-1:H]) * DW'(dm_s3[H-1:0]);
		pll_s4  <= dm_s3[H-1:0] * dm_s3[H-1:0];

		near_s5 <= ang_s4 && (CMPW'(lhs) < CMPW'(rhs));
	end

	assign near = near_s5;

endmodule
`default_nettype wire

>>> hw/rtl/line_segment_merge_table.sv
// Line segment merge table.
// Command channel: an item is taken at a rising edge with start high and
// busy low. op selects add segment, read entry or clear table. Each item
// gives one result on the output ports for exactly one cycle, flagged by
// done; the receiver cannot stall, so results are never held back.
// Configuration: cfg_valid/cfg_ready write angle_limit (index 0) or
// dist_limit (index 1); cfg_ready is always high. Write only while idle.
// Sequence per item:
//   add:          the slope divider (the angle rotator runs alongside),
//                 intercept and bound set-up in S_INTC, S_RHS and S_RHS2,
//                 then one ring rotation of MAX_LINES steps where each stored
//                 line that is compared holds the ring for the near test,
//                 then the result strobe.
//   read:         one ring rotation when the entry exists, else a strobe from idle.
//   clear/other:  the result is strobed straight from idle.
// The table lives in a ring of MAX_LINES cells that rotate past a single
// near-test unit; one item is in work at a time.
// Reset empties the table and loads the register defaults; entries are
// not cleared, as only stored lines are ever read.
`default_nettype none
module line_segment_merge_table #(
	parameter int MAX_LINES  = lsmt_pkg::DEF_MAX_LINES,
	parameter int COORD_BITS = lsmt_pkg::DEF_COORD_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [1:0]                            op,
	input  wire logic [COORD_BITS-1:0]                 x_start,
	input  wire logic [COORD_BITS-1:0]                 y_start,
	input  wire logic [COORD_BITS-1:0]                 x_end,
	input  wire logic [COORD_BITS-1:0]                 y_end,
	input  wire logic [lsmt_pkg::EI_W-1:0]             read_index,
	output logic                                       done,
	output logic [lsmt_pkg::EI_W-1:0]                  entry_index,
	output logic                                       merged,
	output logic                                       dropped,
	output logic signed [lsmt_pkg::SLOPE_W-1:0]        out_slope,
	output logic signed [lsmt_pkg::SLOPE_W-1:0]        out_intercept,
	output logic [lsmt_pkg::OUT_X_W-1:0]               out_x_low,
	output logic [lsmt_pkg::OUT_X_W-1:0]               out_x_high,
	output logic [lsmt_pkg::CNT_W-1:0]                 entry_count,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [lsmt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [lsmt_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int CB  = COORD_BITS;
	localparam int IW  = $clog2(MAX_LINES);
	localparam int TW  = $clog2(MAX_LINES + 1);
	localparam int NQ  = CB + 16;
	localparam int SW  = lsmt_pkg::SLOPE_W;
	localparam int AGW = lsmt_pkg::ANG_W;
	localparam int EW  = 2 * SW + AGW + 2 * CB;
	localparam int IPW = CB + 34;
	localparam int WTW = $clog2(lsmt_pkg::NEAR_LAT + 1);
	localparam int CPW = 9;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_INTC,
		S_RHS,
		S_RHS2,
		S_SCAN
	} state_t;

	state_t state_q;
	logic   busy_q, done_q;

	// configuration
	logic [lsmt_pkg::ALIM_W-1:0] angle_limit_q;
	logic [lsmt_pkg::DLIM_W-1:0] dist_limit_q;

	// segment under work
	logic signed [CB:0]       dx_q, dy_q;
	logic [CB-1:0]            xs_q, ys_q, xl_q, xh_q;
	logic signed [SW-1:0]     s_q, b_q;
	logic signed [AGW-1:0]    a_q;
	logic [23:0]              k2_q;
	logic [63:0]              smsq_q;
	logic [55:0]              rp_hi_q, rp_lo_q;
	logic [lsmt_pkg::RHS_W-1:0] rhs_q;

	// scan control
	logic                     is_add_q;
	logic [lsmt_pkg::EI_W-1:0] ridx_q;
	logic [IW-1:0]            pos_q;
	logic [WTW-1:0]           wait_q;
	logic                     found_q;
	logic [TW-1:0]            total_q;

	// result
	logic [IW-1:0]            idx_q;
	logic                     merged_q, dropped_q;
	logic signed [SW-1:0]     os_q, oi_q;
	logic [CB-1:0]            oxl_q, oxh_q;

	logic                     accept;
	logic signed [CB:0]       dx_in, dy_in;
	logic [CB-1:0]            dx_mag, dy_mag;
	logic                     div_done;
	logic [NQ-1:0]            quot;
	logic signed [AGW-1:0]    angle;
	logic                     near;

	logic [EW-1:0]            cell_q [MAX_LINES];
	logic [EW-1:0]            head, head_new, seg_entry;
	logic signed [SW-1:0]     h_slope, h_icpt;
	logic signed [AGW-1:0]    h_angle;
	logic [CB-1:0]            h_xl, h_xh, m_xl, m_xh;
	logic                     need_cmp, hold, shift_en, hit, app, last, rd_hit;

	logic [33:0]              qx;
	logic signed [SW-1:0]     s_new;
	logic signed [IPW-1:0]    icpt_full;
	logic [SW-1:0]            sm;
	logic [63:0]              t_sum;

	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;

	// segment deltas straight from the ports
	assign dx_in  = $signed({1'b0, x_start}) - $signed({1'b0, x_end});
	assign dy_in  = $signed({1'b0, y_start}) - $signed({1'b0, y_end});
	assign dx_mag = dx_in[CB] ? CB'(-dx_in) : CB'(dx_in);
	assign dy_mag = dy_in[CB] ? CB'(-dy_in) : CB'(dy_in);

	lsmt_div #(.CB(CB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (op == lsmt_pkg::OP_ADD)),
		.num    (dy_mag),
		.den    (dx_mag),
		.done   (div_done),
		.quot   (quot)
	);

	lsmt_cordic #(.CB(CB)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (op == lsmt_pkg::OP_ADD)),
		.dx     (dx_in),
		.dy     (dy_in),
		.angle  (angle)
	);

	// ring of entry cells; the head feeds the near test
	for (genvar k = 0; k < MAX_LINES; k++) begin : g_cell
		if (k == MAX_LINES - 1) begin : g_tail
			lsmt_cell #(.EW(EW)) u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.d_in     (head_new),
				.q        (cell_q[k])
			);
		end else begin : g_body
			lsmt_cell #(.EW(EW)) u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.d_in     (cell_q[k+1]),
				.q        (cell_q[k])
			);
		end
	end

	assign head    = cell_q[0];
	assign h_slope = head[EW-1 -: SW];
	assign h_icpt  = head[EW-SW-1 -: SW];
	assign h_angle = head[2*CB+AGW-1 -: AGW];
	assign h_xl    = head[2*CB-1 -: CB];
	assign h_xh    = head[CB-1:0];

	lsmt_near #(.CB(CB)) u_near (
		.clk         (clk),
		.seg_slope   (s_q),
		.seg_icpt    (b_q),
		.seg_angle   (a_q),
		.seg_xl      (xl_q),
		.seg_xh      (xh_q),
		.ln_slope    (h_slope),
		.ln_icpt     (h_icpt),
		.ln_angle    (h_angle),
		.ln_xl       (h_xl),
		.ln_xh       (h_xh),
		.angle_limit (angle_limit_q),
		.rhs         (rhs_q),
		.near        (near)
	);

	// ring step decision
	assign seg_entry = {s_q, b_q, a_q, xl_q, xh_q};
	assign m_xl      = (h_xl > xl_q) ? xl_q : h_xl;
	assign m_xh      = (h_xh < xh_q) ? xh_q : h_xh;
	assign need_cmp  = (state_q == S_SCAN) && is_add_q && !found_q
		&& (CPW'(pos_q) < CPW'(total_q));
	assign hold      = need_cmp && (wait_q != WTW'(lsmt_pkg::NEAR_LAT));
	assign shift_en  = (state_q == S_SCAN) && !hold;
	assign hit       = need_cmp && !hold && near;
	assign app       = (state_q == S_SCAN) && is_add_q && !found_q
		&& (CPW'(pos_q) == CPW'(total_q)) && (CPW'(total_q) < CPW'(MAX_LINES));
	assign last      = pos_q == IW'(MAX_LINES - 1);
	assign rd_hit    = !is_add_q && (CPW'(pos_q) == CPW'(ridx_q));

	always_comb begin
		head_new = head;
		if (hit) begin
			head_new = {h_slope, h_icpt, h_angle, m_xl, m_xh};
		end else if (app) begin
			head_new = seg_entry;
		end
	end

	// slope from the quotient, saturated; vertical lines pin to the rails
	assign qx = 34'(quot);
	always_comb begin
		if (dx_q == '0) begin
			if (dy_q > 0) begin
				s_new = lsmt_pkg::S_MAX;
			end else if (dy_q < 0) begin
				s_new = lsmt_pkg::S_MIN;
			end else begin
				s_new = '0;
			end
		end else if (dx_q[CB] ^ dy_q[CB]) begin
			s_new = (qx > 34'h080000000) ? lsmt_pkg::S_MIN : SW'(-qx);
		end else begin
			s_new = (qx > 34'h07FFFFFFF) ? lsmt_pkg::S_MAX : SW'(qx);
		end
	end

	assign icpt_full = $signed({1'b0, ys_q, 16'b0}) - s_q * $signed({1'b0, xs_q});
	assign sm        = s_q[SW-1] ? SW'(-s_q) : SW'(s_q);
	assign t_sum     = smsq_q + 64'h1_0000_0000;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_limit_q <= lsmt_pkg::ANGLE_LIMIT_RST;
			dist_limit_q  <= lsmt_pkg::DIST_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (lsmt_pkg::cfg_reg_t'(cfg_index))
				lsmt_pkg::REG_ANGLE_LIMIT: angle_limit_q <= cfg_data;
				lsmt_pkg::REG_DIST_LIMIT:  dist_limit_q  <= cfg_data[lsmt_pkg::DLIM_W-1:0];
			endcase
		end
	end

	// segment data path
	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q <= dx_in;
			dy_q <= dy_in;
			xs_q <= x_start;
			ys_q <= y_start;
			xl_q <= (x_start < x_end) ? x_start : x_end;
			xh_q <= (x_start < x_end) ? x_end : x_start;
		end
		if (state_q == S_DIV && div_done) begin
			s_q <= s_new;
		end
		if (state_q == S_INTC) begin
			if (icpt_full > IPW'(lsmt_pkg::S_MAX)) begin
				b_q <= lsmt_pkg::S_MAX;
			end else if (icpt_full < IPW'(lsmt_pkg::S_MIN)) begin
				b_q <= lsmt_pkg::S_MIN;
			end else begin
				b_q <= SW'(icpt_full);
			end
			a_q    <= angle;
			k2_q   <= 24'(dist_limit_q) * 24'(dist_limit_q);
			smsq_q <= 64'(sm) * 64'(sm);
		end
		if (state_q == S_RHS) begin
			rp_hi_q <= 56'(k2_q) * 56'(t_sum[63:32]);
			rp_lo_q <= 56'(k2_q) * 56'(t_sum[31:0]);
		end
		if (state_q == S_RHS2) begin
			rhs_q <= (lsmt_pkg::RHS_W'(rp_hi_q) << 32) + lsmt_pkg::RHS_W'(rp_lo_q);
		end
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			is_add_q  <= 1'b0;
			ridx_q    <= '0;
			pos_q     <= '0;
			wait_q    <= '0;
			found_q   <= 1'b0;
			total_q   <= '0;
			idx_q     <= '0;
			merged_q  <= 1'b0;
			dropped_q <= 1'b0;
			os_q      <= '0;
			oi_q      <= '0;
			oxl_q     <= '0;
			oxh_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q     <= '0;
						merged_q  <= 1'b0;
						dropped_q <= 1'b0;
						os_q      <= '0;
						oi_q      <= '0;
						oxl_q     <= '0;
						oxh_q     <= '0;
						ridx_q    <= read_index;
						pos_q     <= '0;
						wait_q    <= '0;
						found_q   <= 1'b0;
						unique case (lsmt_pkg::op_t'(op))
							lsmt_pkg::OP_ADD: begin
								is_add_q <= 1'b1;
								busy_q   <= 1'b1;
								state_q  <= S_DIV;
							end
							lsmt_pkg::OP_READ: begin
								is_add_q <= 1'b0;
								idx_q    <= IW'(read_index);
								if (CPW'(read_index) < CPW'(total_q)) begin
									busy_q  <= 1'b1;
									state_q <= S_SCAN;
								end else begin
									done_q <= 1'b1;
								end
							end
							lsmt_pkg::OP_CLEAR: begin
								total_q <= '0;
								done_q  <= 1'b1;
							end
							lsmt_pkg::OP_NONE: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_INTC;
					end
				end
				S_INTC: begin
					state_q <= S_RHS;
				end
				S_RHS: begin
					state_q <= S_RHS2;
				end
				S_RHS2: begin
					wait_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hold) begin
						wait_q <= wait_q + 1'b1;
					end else begin
						wait_q <= '0;
						pos_q  <= last ? '0 : pos_q + 1'b1;
						if (hit) begin
							found_q  <= 1'b1;
							idx_q    <= pos_q;
							merged_q <= 1'b1;
							os_q     <= h_slope;
							oi_q     <= h_icpt;
							oxl_q    <= m_xl;
							oxh_q    <= m_xh;
						end
						if (app) begin
							found_q <= 1'b1;
							total_q <= total_q + 1'b1;
							idx_q   <= pos_q;
							os_q    <= s_q;
							oi_q    <= b_q;
							oxl_q   <= xl_q;
							oxh_q   <= xh_q;
						end
						if (rd_hit) begin
							os_q  <= h_slope;
							oi_q  <= h_icpt;
							oxl_q <= h_xl;
							oxh_q <= h_xh;
						end
						if (last) begin
							// table full and no match: drop with own data
							if (is_add_q && !found_q && !hit && !app) begin
								idx_q     <= '0;
								dropped_q <= 1'b1;
								os_q      <= s_q;
								oi_q      <= b_q;
								oxl_q     <= xl_q;
								oxh_q     <= xh_q;
							end
							done_q  <= 1'b1;
							busy_q  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign entry_index   = lsmt_pkg::EI_W'(idx_q);
	assign merged        = merged_q;
	assign dropped       = dropped_q;
	assign out_slope     = os_q;
	assign out_intercept = oi_q;
	assign out_x_low     = lsmt_pkg::OUT_X_W'(oxl_q);
	assign out_x_high    = lsmt_pkg::OUT_X_W'(oxh_q);
	assign entry_count   = lsmt_pkg::CNT_W'(total_q);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while still busy");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(MAX_LINES))
		else $error("line count beyond table size");

	a_merge_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(merged && dropped))
		else $error("item both merged and dropped");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == lsmt_pkg::OP_CLEAR) |=> (done && entry_count == '0))
		else $error("clear did not empty the table");

	a_hold_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && hold) |=> $stable(pos_q))
		else $error("ring moved during a compare");

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam int LINES = 64;

	typedef struct packed {
		logic [lsmt_pkg::EI_W-1:0]           idx;
		logic                                mrg;
		logic                                drp;
		logic signed [lsmt_pkg::SLOPE_W-1:0] slope;
		logic signed [lsmt_pkg::SLOPE_W-1:0] icpt;
		logic [lsmt_pkg::OUT_X_W-1:0]        xl;
		logic [lsmt_pkg::OUT_X_W-1:0]        xh;
		logic [lsmt_pkg::CNT_W-1:0]          cnt;
	} line_res_t;

	// Hand-written rows: typed ones carry an index and count with all data zero
	typedef struct {
		lsmt_pkg::op_t op;
		int            xs, ys, xe, ye, ri;
		bit            typed;
		int            e_idx, e_cnt;
	} seg_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = '0;
	logic [11:0] x_start = '0, y_start = '0, x_end = '0, y_end = '0;
	logic [lsmt_pkg::EI_W-1:0] read_index = '0;
	logic cfg_valid = 1'b0;
	logic [lsmt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lsmt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	wire busy, done, merged, dropped, cfg_ready;
	wire [lsmt_pkg::EI_W-1:0] entry_index;
	wire signed [lsmt_pkg::SLOPE_W-1:0] out_slope, out_intercept;
	wire [lsmt_pkg::OUT_X_W-1:0] out_x_low, out_x_high;
	wire [lsmt_pkg::CNT_W-1:0] entry_count;

	line_segment_merge_table dut (.*);

	always #6 clk = ~clk;

	// Predictor state
	int        ln_slope[LINES], ln_icpt[LINES], ln_angle[LINES];
	int        ln_xl[LINES], ln_xh[LINES];
	int        ln_total;
	int        ang_lim = 768, dst_lim = 5;
	line_res_t pending_lines[$];
	int        fails = 0;
	bit        gaps_on = 1'b1;

	const longint atan_q16[16] = '{2950616, 1741850, 920346, 467182, 234498, 117363,
		58696, 29350, 14675, 7338, 3669, 1834, 917, 459, 229, 115};

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint shr_zero(longint v, int s);
		return v >= 0 ? (v >>> s) : -((-v) >>> s);
	endfunction

	// Rotate (dx, dy) onto the x axis; accumulated angle in 1/65536 degree
	function automatic int seg_angle_q88(longint dx, longint dy);
		longint x, y, z, nx, ny;
		z = 0;
		if (dx < 0) begin
			dx = -dx;
			dy = -dy;
		end
		if (dy == 0) return 0;
		x = dx * 1024;
		y = dy * 1024;
		for (int i = 0; i < 16; i++) begin
			if (y > 0) begin
				nx = x + shr_zero(y, i); ny = y - shr_zero(x, i); z += atan_q16[i];
			end else begin
				nx = x - shr_zero(y, i); ny = y + shr_zero(x, i); z -= atan_q16[i];
			end
			x = nx;
			y = ny;
		end
		return int'(z >= 0 ? (z + 128) >>> 8 : -((-z + 128) >>> 8));
	endfunction

	// Angle and offset test against stored line j
	function automatic bit seg_is_close(int s0, int b0, int a0, int xl0, int xh0, int j);
		longint ad, xsel, d, dm, sm, k2;
		logic [127:0] lhs, rhs;
		ad = longint'(a0) - ln_angle[j];
		if (ad < 0) ad = -ad;
		if (!(ad < ang_lim)) return 1'b0;
		if (xh0 < ln_xl[j]) xsel = xh0;
		else if (xl0 > ln_xh[j]) xsel = ln_xh[j];
		else if (xh0 < ln_xh[j]) xsel = xh0;
		else xsel = xl0;
		d = xsel * (longint'(s0) - ln_slope[j]) + (longint'(b0) - ln_icpt[j]);
		dm = d < 0 ? -d : d;
		sm = s0 < 0 ? -longint'(s0) : longint'(s0);
		k2 = longint'(dst_lim) * dst_lim;
		lhs = 128'(dm) * 128'(dm);
		rhs = 128'(k2) * 128'(sm * sm + (64'sd1 <<< 32));
		return lhs < rhs;
	endfunction

	// Work out the result of one item and update the table copy
	function automatic line_res_t predict_line(lsmt_pkg::op_t o, int xs, int ys, int xe,
			int ye, int ri);
		line_res_t r;
		longint dx, dy;
		int s, b, a, xl, xh;
		bit hit;
		r = '0;
		hit = 1'b0;
		if (o == lsmt_pkg::OP_ADD) begin
			dx = xs - xe;
			dy = ys - ye;
			if (dx != 0) s = int'(clamp32((dy * 65536) / dx));
			else if (dy > 0) s = 32'sh7FFFFFFF;
			else if (dy < 0) s = 32'sh80000000;
			else s = 0;
			b = int'(clamp32(longint'(ys) * 65536 - longint'(s) * xs));
			a = seg_angle_q88(dx, dy);
			xl = xs < xe ? xs : xe;
			xh = xs < xe ? xe : xs;
			for (int j = 0; j < ln_total && !hit; j++) begin
				if (seg_is_close(s, b, a, xl, xh, j)) begin
					if (ln_xl[j] > xl) ln_xl[j] = xl;
					if (ln_xh[j] < xh) ln_xh[j] = xh;
					r.idx = lsmt_pkg::EI_W'(j); r.mrg = 1'b1;
					r.slope = ln_slope[j]; r.icpt = ln_icpt[j];
					r.xl = lsmt_pkg::OUT_X_W'(ln_xl[j]);
					r.xh = lsmt_pkg::OUT_X_W'(ln_xh[j]);
					hit = 1'b1;
				end
			end
			if (!hit) begin
				if (ln_total < LINES) begin
					ln_slope[ln_total] = s; ln_icpt[ln_total] = b; ln_angle[ln_total] = a;
					ln_xl[ln_total] = xl; ln_xh[ln_total] = xh;
					r.idx = lsmt_pkg::EI_W'(ln_total);
					ln_total++;
				end else begin
					r.drp = 1'b1;
				end
				r.slope = s; r.icpt = b;
				r.xl = lsmt_pkg::OUT_X_W'(xl); r.xh = lsmt_pkg::OUT_X_W'(xh);
			end
		end else if (o == lsmt_pkg::OP_READ) begin
			r.idx = lsmt_pkg::EI_W'(ri);
			if (ri < ln_total) begin
				r.slope = ln_slope[ri]; r.icpt = ln_icpt[ri];
				r.xl = lsmt_pkg::OUT_X_W'(ln_xl[ri]); r.xh = lsmt_pkg::OUT_X_W'(ln_xh[ri]);
			end
		end else if (o == lsmt_pkg::OP_CLEAR) begin
			ln_total = 0;
		end
		r.cnt = lsmt_pkg::CNT_W'(ln_total);
		return r;
	endfunction

	// Offer one item, hold it until taken, then queue its expected result
	task automatic send_item(lsmt_pkg::op_t o, int xs, int ys, int xe, int ye, int ri,
			bit typed, int e_idx, int e_cnt);
		int gap;
		line_res_t r;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		x_start <= 12'(xs); y_start <= 12'(ys); x_end <= 12'(xe); y_end <= 12'(ye);
		read_index <= lsmt_pkg::EI_W'(ri);
		do @(posedge clk); while (busy);
		r = predict_line(o, xs, ys, xe, ye, ri);
		if (typed) begin
			r = '0;
			r.idx = lsmt_pkg::EI_W'(e_idx);
			r.cnt = lsmt_pkg::CNT_W'(e_cnt);
		end
		pending_lines = {pending_lines, r};
	endtask

	// Drain outstanding items, then write one register
	task automatic write_reg(lsmt_pkg::cfg_reg_t idx, int val);
		start <= 1'b0;
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= lsmt_pkg::CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == lsmt_pkg::REG_ANGLE_LIMIT) ang_lim = val & 16'hFFFF;
		else dst_lim = val & 12'hFFF;
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		line_res_t got, want;
		if (arst_n && done) begin
			got = '{entry_index, merged, dropped, out_slope, out_intercept,
				out_x_low, out_x_high, entry_count};
			if (pending_lines.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result idx=%0d cnt=%0d", entry_index, entry_count);
			end else begin
				want = pending_lines.pop_front();
				if (got !== want) begin
					fails++;
					if (fails <= 10) begin
						$display("mismatch exp idx=%0d m=%0d d=%0d s=%h b=%h xl=%0d xh=%0d cnt=%0d",
							want.idx, want.mrg, want.drp, want.slope, want.icpt, want.xl,
							want.xh, want.cnt);
						$display("         got idx=%0d m=%0d d=%0d s=%h b=%h xl=%0d xh=%0d cnt=%0d",
							got.idx, got.mrg, got.drp, got.slope, got.icpt, got.xl,
							got.xh, got.cnt);
					end
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int clip_px(int v);
		return v < 0 ? 0 : (v > 4095 ? 4095 : v);
	endfunction

	initial begin
		seg_row_t rows[20];
		int base[8][4];
		int alims[6], dlims[6], clr_pct[6];
		int k, c, j, ri;
		rows = '{
			'{lsmt_pkg::OP_READ, 0, 0, 0, 0, 63, 1, 63, 0},
			'{lsmt_pkg::OP_NONE, 4095, 4095, 4095, 4095, 0, 1, 0, 0},
			'{lsmt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0},
			'{lsmt_pkg::OP_ADD, 0, 100, 4095, 100, 0, 0, 0, 0},
			'{lsmt_pkg::OP_ADD, 2000, 4095, 2000, 0, 0, 0, 0, 0},
			'{lsmt_pkg::OP_ADD, 4095, 0, 4095, 4095, 0, 0, 0, 0},
			'{lsmt_pkg::OP_ADD, 4095, 4095, 4095, 4095, 0, 0, 0, 0},
			'{lsmt_pkg::OP_ADD, 0, 0, 4095, 4095, 0, 0, 0, 0},
			'{lsmt_pkg::OP_ADD, 4095, 0, 0, 4095, 0, 0, 0, 0},
			'{lsmt_pkg::OP_ADD, 10, 101, 300, 101, 0, 0, 0, 0},
			'{lsmt_pkg::OP_ADD, 2000, 0, 2000, 4000, 0, 0, 0, 0},
			'{lsmt_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0},
			'{lsmt_pkg::OP_READ, 0, 0, 0, 0, 1, 0, 0, 0},
			'{lsmt_pkg::OP_READ, 0, 0, 0, 0, 63, 0, 0, 0},
			'{lsmt_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0},
			'{lsmt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0},
			'{lsmt_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 0, 0},
			'{lsmt_pkg::OP_ADD, 4095, 4095, 0, 0, 0, 0, 0, 0},
			'{lsmt_pkg::OP_ADD, 1, 2, 0, 0, 0, 0, 0, 0},
			'{lsmt_pkg::OP_ADD, 0, 4095, 1, 0, 0, 0, 0, 0}
		};
		// Register settings per phase; the zero angle bound fills the table
		alims = '{768, 46080, 0, 3000, 256, 46080};
		dlims = '{5, 4095, 0, 200, 1, 0};
		clr_pct = '{4, 4, 0, 3, 4, 3};
		ln_total = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at reset settings
		foreach (rows[i])
			send_item(rows[i].op, rows[i].xs, rows[i].ys, rows[i].xe, rows[i].ye,
				rows[i].ri, rows[i].typed, rows[i].e_idx, rows[i].e_cnt);

		// Random phases
		for (int p = 0; p < 6; p++) begin
			write_reg(lsmt_pkg::REG_ANGLE_LIMIT, alims[p]);
			write_reg(lsmt_pkg::REG_DIST_LIMIT, dlims[p] | ($urandom_range(0, 15) << 12));
			gaps_on = (p != 1);
			for (int b = 0; b < 8; b++)
				for (int e = 0; e < 4; e++) base[b][e] = $urandom_range(0, 4095);
			for (int n = 0; n < 275; n++) begin
				k = $urandom_range(0, 99);
				if (k < 60) begin
					// segment close to one of a few base lines
					c = $urandom_range(0, 7);
					j = $urandom_range(0, 3) == 0 ? 40 : 3;
					send_item(lsmt_pkg::OP_ADD,
						clip_px(base[c][0] + $urandom_range(0, 2 * j) - j),
						clip_px(base[c][1] + $urandom_range(0, 2 * j) - j),
						clip_px(base[c][2] + $urandom_range(0, 2 * j) - j),
						clip_px(base[c][3] + $urandom_range(0, 2 * j) - j), 0, 0, 0, 0);
				end else if (k < 75) begin
					send_item(lsmt_pkg::OP_ADD, $urandom_range(0, 4095),
						$urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(0, 4095), $urandom_range(0, 63), 0, 0, 0);
				end else if (k < 93) begin
					ri = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
						: $urandom_range(0, ln_total > 0 ? ln_total - 1 : 0);
					send_item(lsmt_pkg::OP_READ, $urandom_range(0, 4095),
						$urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(0, 4095), ri, 0, 0, 0);
				end else if (k < 93 + clr_pct[p]) begin
					send_item(lsmt_pkg::OP_CLEAR, 0, 0, 0, 0, $urandom_range(0, 63),
						0, 0, 0);
				end else begin
					send_item(lsmt_pkg::OP_NONE, $urandom_range(0, 4095), 0, 0,
						$urandom_range(0, 4095), $urandom_range(0, 63), 0, 0, 0);
				end
			end
		end

		// Drain and let the block settle
		start <= 1'b0;
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (fails == 0 && pending_lines.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
